[design/ntcbt_pkg.sv]
`default_nettype none
package ntcbt_pkg;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_VOLT  = 3'd1;
  localparam logic [2:0] ST_BAD_CFG   = 3'd2;
  localparam logic [2:0] ST_INV_NEG   = 3'd3;
  localparam logic [2:0] ST_RES_SAT   = 3'd4;
  localparam logic [2:0] ST_TEMP_SAT  = 3'd5;

  // register indexes
  localparam logic [1:0] REG_FIXED_R  = 2'd0;
  localparam logic [1:0] REG_NOM_R    = 2'd1;
  localparam logic [1:0] REG_BETA     = 2'd2;
  localparam logic [1:0] REG_NOM_T    = 2'd3;

  localparam int CFG_W     = 24;
  localparam int FRAC_BITS = 24;
  localparam int LOG_W     = 30;  // Q6.24 log2, 6 integer bits
  localparam int DIV1_W    = 47;  // numerator of the two divides after the log
  localparam int QDIV_N    = 49;
  localparam int QDIV_D    = 48;
  localparam int TEMP_W    = 21;

  localparam logic [31:0]       LN2_Q32      = 32'd2977044472;
  localparam logic [DIV1_W-1:0] INV_NUM      = 47'd109951162777600;  // 100 * 2^40
  localparam logic [16:0]       KELVIN_CENTI = 17'd27315;
  localparam logic [20:0]       KELVIN_T     = 21'd27315;
  localparam logic [20:0]       TEMP_MAX     = 21'd1000000;
  localparam logic [QDIV_N-1:0] Q_LIMIT      = 49'd1027315;
  localparam logic [15:0]       T0_RST       = 16'd2500;
  localparam logic [15:0]       T0_MIN       = 16'h954D;  // -27315

endpackage
`default_nettype wire

[design/ntcbt_div.sv]
`default_nettype none
module ntcbt_div
  import ntcbt_pkg::*;
#(
  parameter int NUM_W = 8,
  parameter int DEN_W = 8,
  parameter int SB_W  = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [SB_W-1:0]  side,
  output logic             out_valid,
  output logic [NUM_W-1:0] quot,
  output logic [SB_W-1:0]  out_side
);

  // one restoring step per stage; nq shifts numerator bits out and quotient bits in
  logic [DEN_W-1:0] rem   [NUM_W];
  logic [NUM_W-1:0] nq    [NUM_W];
  logic [DEN_W-1:0] den_s [NUM_W];
  logic [SB_W-1:0]  sd    [NUM_W];
  logic [NUM_W-1:0] vld;

  function automatic logic [DEN_W+NUM_W-1:0] step(input logic [DEN_W-1:0] r,
                                                 input logic [NUM_W-1:0] n,
                                                 input logic [DEN_W-1:0] d);
    logic [DEN_W:0] r2;
    logic [DEN_W:0] sub;
    logic           ge;
    r2  = {r, n[NUM_W-1]};
    sub = r2 - {1'b0, d};
    ge  = (r2 >= {1'b0, d});
    return {(ge ? sub[DEN_W-1:0] : r2[DEN_W-1:0]), n[NUM_W-2:0], ge};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NUM_W-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    {rem[0], nq[0]} <= step('0, num, den);
    den_s[0] <= den;
    sd[0]    <= side;
    for (int i = 1; i < NUM_W; i++) begin
      {rem[i], nq[i]} <= step(rem[i-1], nq[i-1], den_s[i-1]);
      den_s[i] <= den_s[i-1];
      sd[i]    <= sd[i-1];
    end
  end

  assign out_valid = vld[NUM_W-1];
  assign quot      = nq[NUM_W-1];
  assign out_side  = sd[NUM_W-1];

endmodule
`default_nettype wire

[design/ntcbt_log2.sv]
`default_nettype none
module ntcbt_log2
  import ntcbt_pkg::*;
#(
  parameter int LW   = 32,
  parameter int SB_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [LW-1:0]    a,
  input  logic [LW-1:0]    b,
  input  logic [SB_W-1:0]  side,
  output logic             out_valid,
  output logic [LOG_W-1:0] log_a,
  output logic [LOG_W-1:0] log_b,
  output logic [SB_W-1:0]  out_side
);

  localparam int NS = FRAC_BITS + 1;

  // stage 0 normalizes, each later stage squares the mantissa for one fraction bit
  logic [31:0]      ma [NS];
  logic [31:0]      mb [NS];
  logic [LOG_W-1:0] aa [NS];
  logic [LOG_W-1:0] ab [NS];
  logic [SB_W-1:0]  sd [NS];
  logic [NS-1:0]    vld;

  function automatic logic [LOG_W+31:0] norm(input logic [LW-1:0] x);
    logic [5:0]     k;
    logic [LW+31:0] y;
    k = '0;
    for (int i = 0; i < LW; i++) begin
      if (x[i]) k = 6'(i);
    end
    y = {x, 32'b0} << (6'(LW - 1) - k);
    return {k, 24'b0, y[LW+31 -: 32]};
  endfunction

  function automatic logic [LOG_W+31:0] sq(input logic [LOG_W-1:0] acc,
                                           input logic [31:0] m,
                                           input logic [4:0] pos);
    logic [63:0] p;
    logic [32:0] t;
    p = m * m;
    t = p[63:31];
    return {acc | (LOG_W'(t[32]) << pos), (t[32] ? t[32:1] : t[31:0])};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    {aa[0], ma[0]} <= norm(a);
    {ab[0], mb[0]} <= norm(b);
    sd[0] <= side;
    for (int j = 1; j < NS; j++) begin
      {aa[j], ma[j]} <= sq(aa[j-1], ma[j-1], 5'(FRAC_BITS - j));
      {ab[j], mb[j]} <= sq(ab[j-1], mb[j-1], 5'(FRAC_BITS - j));
      sd[j] <= sd[j-1];
    end
  end

  assign out_valid = vld[NS-1];
  assign log_a     = aa[NS-1];
  assign log_b     = ab[NS-1];
  assign out_side  = sd[NS-1];

endmodule
`default_nettype wire

[design/ntc_divider_beta_temperature.sv]
// NTC thermistor temperature from a divider reading, beta equation.
// Input: pulse start with supply_mv and node_mv; a transaction is taken at a
// clock edge where start is high and busy is low. busy is high only in reset.
// Output: done is high for one cycle with ok, status, therm_ohm and
// temperature_centi_c; the receiver takes it then and cannot hold it off.
// Configuration: cfg_write with cfg_index and cfg_data writes one register at
// the clock edge; write only while no transaction is in flight.
// Throughput: one transaction per cycle, fully pipelined.
// The pipeline is the chain of one-bit-per-stage divides (resistance, ln/beta
// and 1/T0, final 1/inv) and the 25-stage log2 squaring pipeline.
// Reset: registers take their reset values and all in-flight transactions are
// dropped; no done appears until a new transaction has passed the pipeline.
`default_nettype none
module ntc_divider_beta_temperature
  import ntcbt_pkg::*;
#(
  parameter int VOLT_BITS = 16,
  parameter int RES_BITS  = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [VOLT_BITS-1:0] supply_mv,
  input  logic [VOLT_BITS-1:0] node_mv,
  input  logic                 cfg_write,
  input  logic [1:0]           cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic                 done,
  output logic                 ok,
  output logic [2:0]           status,
  output logic [RES_BITS-1:0]  therm_ohm,
  output logic signed [TEMP_W-1:0] temperature_centi_c
);

  localparam int NR = VOLT_BITS + 26;
  localparam int QW = (NR > RES_BITS + 1) ? NR : RES_BITS + 1;
  localparam int LW = (RES_BITS > 24) ? RES_BITS : 24;
  localparam int SW = RES_BITS + 2;

  logic [23:0] fixed_r;
  logic [23:0] nom_r;
  logic [15:0] beta;
  logic [15:0] nom_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      fixed_r <= 24'd10000;
      nom_r   <= 24'd10000;
      beta    <= 16'd3950;
      nom_t   <= T0_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FIXED_R: fixed_r <= cfg_data;
        REG_NOM_R:   nom_r   <= cfg_data;
        REG_BETA:    beta    <= cfg_data[15:0];
        REG_NOM_T:   nom_t   <= cfg_data[15:0];
        default:     ;
      endcase
    end
  end

  assign busy = rst;
  logic accept;
  assign accept = start & ~busy;

  // stage 1: voltage checks and fixed * node
  logic                    s1_vld;
  logic                    s1_bad;
  logic [VOLT_BITS-1:0]    s1_diff;
  logic [VOLT_BITS+23:0]   s1_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_bad  <= (supply_mv == '0) | (node_mv == '0) | (node_mv >= supply_mv);
    s1_diff <= supply_mv - node_mv;
    s1_prod <= fixed_r * node_mv;
  end

  // resistance divide, rounded half up
  logic          rd_vld;
  logic [NR-1:0] rd_q;
  logic          rd_bad;

  ntcbt_div #(.NUM_W(NR), .DEN_W(VOLT_BITS + 1), .SB_W(1)) u_res_div (
    .clk(clk), .rst(rst), .in_valid(s1_vld),
    .num(NR'({s1_prod, 1'b0}) + NR'(s1_diff)),
    .den({s1_diff, 1'b0}),
    .side(s1_bad),
    .out_valid(rd_vld), .quot(rd_q), .out_side(rd_bad)
  );

  // stage 2: saturate
  logic                s2_vld;
  logic                s2_bad;
  logic                s2_sat;
  logic [RES_BITS-1:0] s2_res;
  logic [QW-1:0]       rd_qx;

  assign rd_qx = QW'(rd_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= rd_vld;
    end
  end

  always_ff @(posedge clk) begin
    s2_bad <= rd_bad;
    s2_sat <= |(rd_qx >> RES_BITS);
    s2_res <= (|(rd_qx >> RES_BITS)) ? '1 : rd_qx[RES_BITS-1:0];
  end

  // log2 of R and R0
  logic             lg_vld;
  logic [LOG_W-1:0] lg_a;
  logic [LOG_W-1:0] lg_b;
  logic [SW-1:0]    lg_side;

  ntcbt_log2 #(.LW(LW), .SB_W(SW)) u_log (
    .clk(clk), .rst(rst), .in_valid(s2_vld),
    .a(LW'(s2_res)), .b(LW'(nom_r)),
    .side({s2_bad, s2_sat, s2_res}),
    .out_valid(lg_vld), .log_a(lg_a), .log_b(lg_b), .out_side(lg_side)
  );

  // stage 3: difference as sign and magnitude
  logic             s3_vld;
  logic             s3_neg;
  logic [LOG_W-1:0] s3_mag;
  logic [SW-1:0]    s3_side;
  logic [LOG_W:0]   lg_d;

  assign lg_d = {1'b0, lg_a} - {1'b0, lg_b};

  // stage 4: times ln 2
  logic             s4_vld;
  logic             s4_neg;
  logic [LOG_W+31:0] s4_prod;
  logic [SW-1:0]    s4_side;

  // stage 5: round to Q6.24
  logic             s5_vld;
  logic             s5_neg;
  logic [LOG_W-1:0] s5_ln;
  logic [SW-1:0]    s5_side;
  logic [LOG_W+32:0] s4_rnd;

  assign s4_rnd = (LOG_W+33)'(s4_prod) + (LOG_W+33)'(33'h080000000);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
      s5_vld <= 1'b0;
    end else begin
      s3_vld <= lg_vld;
      s4_vld <= s3_vld;
      s5_vld <= s4_vld;
    end
  end

  always_ff @(posedge clk) begin
    s3_neg  <= lg_d[LOG_W];
    s3_mag  <= lg_d[LOG_W] ? LOG_W'(-lg_d) : lg_d[LOG_W-1:0];
    s3_side <= lg_side;
    s4_neg  <= s3_neg;
    s4_prod <= s3_mag * LN2_Q32;
    s4_side <= s3_side;
    s5_neg  <= s4_neg;
    s5_ln   <= s4_rnd[LOG_W+31:32];
    s5_side <= s4_side;
  end

  // ln/beta and 1/T0 divides run side by side
  logic [16:0] tn_full;
  assign tn_full = {nom_t[15], nom_t} + KELVIN_CENTI;

  logic              da_vld;
  logic [DIV1_W-1:0] da_q;
  logic [2:0]        da_side;
  logic              db_vld;
  logic [DIV1_W-1:0] db_q;
  logic [RES_BITS-1:0] db_side;

  ntcbt_div #(.NUM_W(DIV1_W), .DEN_W(16), .SB_W(3)) u_lnb_div (
    .clk(clk), .rst(rst), .in_valid(s5_vld),
    .num(DIV1_W'({s5_ln, 16'b0}) + DIV1_W'(beta[15:1])),
    .den(beta),
    .side({s5_neg, s5_side[SW-1], s5_side[SW-2]}),
    .out_valid(da_vld), .quot(da_q), .out_side(da_side)
  );

  ntcbt_div #(.NUM_W(DIV1_W), .DEN_W(16), .SB_W(RES_BITS)) u_inv0_div (
    .clk(clk), .rst(rst), .in_valid(s5_vld),
    .num(INV_NUM + DIV1_W'(tn_full[15:1])),
    .den(tn_full[15:0]),
    .side(s5_side[RES_BITS-1:0]),
    .out_valid(db_vld), .quot(db_q), .out_side(db_side)
  );

  // stage 6: inverse temperature
  logic                     s6_vld;
  logic signed [QDIV_D:0]   s6_inv;
  logic                     s6_bad;
  logic                     s6_sat;
  logic [RES_BITS-1:0]      s6_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_vld <= 1'b0;
    end else begin
      s6_vld <= da_vld & db_vld;
    end
  end

  always_ff @(posedge clk) begin
    s6_inv <= (QDIV_D+1)'(db_q) +
              (da_side[2] ? -((QDIV_D+1)'(da_q)) : (QDIV_D+1)'(da_q));
    s6_bad <= da_side[1];
    s6_sat <= da_side[0];
    s6_res <= db_side;
  end

  logic inv_bad;
  assign inv_bad = s6_inv[QDIV_D] | (s6_inv == '0);

  logic                qd_vld;
  logic [QDIV_N-1:0]   qd_q;
  logic [SW:0]         qd_side;

  ntcbt_div #(.NUM_W(QDIV_N), .DEN_W(QDIV_D), .SB_W(SW + 1)) u_q_div (
    .clk(clk), .rst(rst), .in_valid(s6_vld),
    .num(QDIV_N'(INV_NUM) + QDIV_N'(s6_inv[QDIV_D-1:1])),
    .den(s6_inv[QDIV_D-1:0]),
    .side({s6_bad, s6_sat, inv_bad, s6_res}),
    .out_valid(qd_vld), .quot(qd_q), .out_side(qd_side)
  );

  // output stage
  logic                f_bad;
  logic                f_sat;
  logic                f_inv;
  logic [RES_BITS-1:0] f_res;
  logic                cfg_bad;
  logic [2:0]          status_next;
  logic [RES_BITS-1:0] res_next;
  logic [TEMP_W-1:0]   temp_next;

  assign {f_bad, f_sat, f_inv, f_res} = qd_side;
  assign cfg_bad = (nom_r == '0) | (beta == '0) | ($signed(nom_t) <= $signed(T0_MIN));

  always_comb begin
    res_next  = f_res;
    temp_next = '0;
    if (f_bad) begin
      status_next = ST_BAD_VOLT;
      res_next    = '0;
    end else if (fixed_r == '0) begin
      status_next = ST_BAD_CFG;
      res_next    = '0;
    end else if (f_sat) begin
      status_next = ST_RES_SAT;
    end else if (cfg_bad) begin
      status_next = ST_BAD_CFG;
    end else if (f_res == '0 || f_inv) begin
      status_next = ST_INV_NEG;
    end else if (qd_q > Q_LIMIT) begin
      status_next = ST_TEMP_SAT;
      temp_next   = TEMP_MAX;
    end else begin
      status_next = ST_OK;
      temp_next   = qd_q[TEMP_W-1:0] - KELVIN_T;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= qd_vld;
    end
  end

  always_ff @(posedge clk) begin
    status              <= status_next;
    ok                  <= (status_next == ST_OK);
    therm_ohm           <= res_next;
    temperature_centi_c <= temp_next;
  end

endmodule
`default_nettype wire

[design/ntcbt_chk.sv]
`default_nettype none
module ntcbt_chk
  import ntcbt_pkg::*;
#(
  parameter int RES_BITS = 32
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      done,
  input logic                      ok,
  input logic [2:0]                status,
  input logic [RES_BITS-1:0]       therm_ohm,
  input logic signed [TEMP_W-1:0]  temperature_centi_c
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  a_ok_status: assert property (@(posedge clk) disable iff (rst)
    done |-> (ok == (status == ST_OK)))
    else $error("ok disagrees with status");

  a_bad_volt_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_BAD_VOLT) |-> (therm_ohm == '0 &&
                                         temperature_centi_c == '0))
    else $error("bad voltage transaction carries data");

  a_fail_temp_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !ok && status != ST_TEMP_SAT) |-> temperature_centi_c == '0)
    else $error("failed transaction carries a temperature");

  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    (done && ok) |-> (temperature_centi_c >= -21'sd27315))
    else $error("temperature below absolute zero");

endmodule

bind ntc_divider_beta_temperature ntcbt_chk #(.RES_BITS(RES_BITS)) u_chk (
  .clk(clk), .rst(rst), .done(done), .ok(ok), .status(status),
  .therm_ohm(therm_ohm), .temperature_centi_c(temperature_centi_c)
);
`default_nettype wire
